// ===== hw/rtl/retransmit_pending_table_assert.svh =====
// Assertion helpers used by the file that checks the table.
`ifndef RETRANSMIT_PENDING_TABLE_ASSERT_SVH
`define RETRANSMIT_PENDING_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("retransmit table check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("retransmit table check failed");

`endif

// ===== hw/rtl/rpt_pkg.sv =====
package rpt_pkg;

  localparam int TABLE_CAPACITY = 16;
  localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);
  localparam int IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;

  localparam int OP_W = 2;
  localparam int TYPE_W = 8;
  localparam int PAYLOAD_W = 64;
  localparam int TIME_W = 32;
  localparam int TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]    msg_type;
    logic [PAYLOAD_W-1:0] msg_payload;
    logic                 wants_ack;
    logic [TIME_W-1:0]    sent_time;
    logic                 unsent;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             write;
    logic             ack;
    logic             step;
    logic             push;
    logic             last;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             due;
    logic             remove;
  } dp_status_t;

endpackage

// ===== hw/rtl/rpt_if.sv =====
interface rpt_cmd_if import rpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [TYPE_W-1:0]    msg_type;
  logic [PAYLOAD_W-1:0] msg_payload;
  logic                 needs_ack;
  logic [TIME_W-1:0]    now_time;
  logic                 link_ready;

  modport source (output valid, operation, msg_type, msg_payload, needs_ack, now_time,
                  link_ready, input ready);
  modport sink (input valid, operation, msg_type, msg_payload, needs_ack, now_time,
                link_ready, output ready);
endinterface

interface rpt_send_if import rpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    send_type;
  logic [PAYLOAD_W-1:0] send_payload;
  logic                 send_accepted;
  logic                 last_send;

  modport source (output valid, send_type, send_payload, send_accepted, last_send,
                  input ready);
  modport sink (input valid, send_type, send_payload, send_accepted, last_send,
                output ready);
endinterface

interface rpt_cfg_if import rpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] retry_timeout;

  modport source (output valid, retry_timeout, input ready);
  modport sink (input valid, retry_timeout, output ready);
endinterface

// ===== hw/rtl/retransmit_pending_table.sv =====
// Table of pending outgoing messages, one entry per message type, up to sixteen.
// Commands arrive on cmd as valid/ready beats: write inserts or replaces an entry
// and marks it unsent, ack removes the entry of its type, tick carries the time
// and the link state and scans the table in ascending type order. A write of a
// new type to a full table evicts the lowest type, or is dropped if it is lower.
// cmd is not ready again until a write or ack is done. In a tick each due entry
// produces one beat on send, and the final beat of the tick has last_send set.
// A tick with nothing due produces no beat. The scan walks one table slot per
// cycle while send lets it; results pass through an output register and a
// one-entry hold stage, so the scan only waits when send is stalled and both are
// full; a stalled beat holds. The retry timeout is written on cfg, which is
// always ready; write it only while the table is idle.
// Reset empties the table, sets the timeout to 500 and drops any pending beat.
`include "retransmit_pending_table_assert.svh"

module retransmit_pending_table import rpt_pkg::*; (
  input logic      clk,
  input logic      rst,
  rpt_cmd_if.sink  cmd,
  rpt_send_if.source send,
  rpt_cfg_if.sink  cfg
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg.ready = 1'b1;

  rpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .operation  (cmd.operation),
    .send_valid (send.valid),
    .send_ready (send.ready),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status)
  );

  rpt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.retry_timeout),
    .msg_type      (cmd.msg_type),
    .msg_payload   (cmd.msg_payload),
    .needs_ack     (cmd.needs_ack),
    .now_time      (cmd.now_time),
    .link_ready    (cmd.link_ready),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status),
    .send_type     (send.send_type),
    .send_payload  (send.send_payload),
    .send_accepted (send.send_accepted),
    .last_send     (send.last_send)
  );

  `RPT_ASSERT_NOW(a_push_free, clk, rst, dp_cmd.push, !send.valid || send.ready)
  `RPT_ASSERT_NOW(a_step_due, clk, rst, dp_cmd.step, dp_status.due)
  `RPT_ASSERT_NEXT(a_tick_busy, clk, rst, cmd.valid && cmd.ready && cmd.operation == OP_TICK,
                   !cmd.ready)
  `RPT_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, dp_status.count <= CNT_W'(TABLE_CAPACITY))

endmodule

// ===== hw/rtl/rpt_datapath.sv =====
module rpt_datapath import rpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  input  logic [TYPE_W-1:0]    msg_type,
  input  logic [PAYLOAD_W-1:0] msg_payload,
  input  logic                 needs_ack,
  input  logic [TIME_W-1:0]    now_time,
  input  logic                 link_ready,
  input  dp_cmd_t              dp_cmd,
  output dp_status_t           dp_status,
  output logic [TYPE_W-1:0]    send_type,
  output logic [PAYLOAD_W-1:0] send_payload,
  output logic                 send_accepted,
  output logic                 last_send
);

  logic [TIMEOUT_W-1:0] timeout;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  entry_t               table_r [TABLE_CAPACITY];
  entry_t               table_next [TABLE_CAPACITY];
  entry_t               above [TABLE_CAPACITY];
  entry_t               below [TABLE_CAPACITY];

  logic [TYPE_W-1:0]    r_type;
  logic [PAYLOAD_W-1:0] r_payload;
  logic                 r_ack;
  logic [TIME_W-1:0]    r_now;
  logic                 r_ready;

  logic [TYPE_W-1:0]    cand_type;
  logic [PAYLOAD_W-1:0] cand_payload;

  entry_t                    cur;
  entry_t                    new_e;
  logic [TIME_W-1:0]         elapsed;
  logic [TABLE_CAPACITY-1:0] hit;
  logic [TABLE_CAPACITY-1:0] lt;
  logic [TABLE_CAPACITY-1:0] lt_above;
  logic [TABLE_CAPACITY-1:0] ins_here;
  logic                      any_hit;
  logic                      full;

  always_comb begin
    cur = table_r[dp_cmd.idx[IDX_W-1:0]];
    elapsed = r_now - cur.sent_time;
    dp_status.count = count;
    dp_status.due = cur.unsent || (elapsed >= TIME_W'(timeout));
    dp_status.remove = r_ready && !cur.wants_ack;

    new_e.msg_type = r_type;
    new_e.msg_payload = r_payload;
    new_e.wants_ack = r_ack;
    new_e.sent_time = '0;
    new_e.unsent = 1'b1;

    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      hit[i] = (CNT_W'(i) < count) && (table_r[i].msg_type == r_type);
      lt[i] = (CNT_W'(i) < count) && (table_r[i].msg_type < r_type);
    end
    any_hit = |hit;
    full = (count == CNT_W'(TABLE_CAPACITY));

    for (int i = 0; i < TABLE_CAPACITY - 1; i++) begin
      above[i] = table_r[i+1];
      lt_above[i] = lt[i+1];
    end
    above[TABLE_CAPACITY-1] = table_r[TABLE_CAPACITY-1];
    lt_above[TABLE_CAPACITY-1] = 1'b0;

    below[0] = table_r[0];
    ins_here[0] = 1'b1;
    for (int i = 1; i < TABLE_CAPACITY; i++) begin
      below[i] = table_r[i-1];
      ins_here[i] = lt[i-1];
    end

    table_next = table_r;
    count_next = count;

    if (dp_cmd.write) begin
      if (any_hit) begin
        for (int i = 0; i < TABLE_CAPACITY; i++) begin
          if (hit[i]) begin
            table_next[i] = new_e;
          end
        end
      end else if (!full) begin
        for (int i = 0; i < TABLE_CAPACITY; i++) begin
          if (!lt[i]) begin
            table_next[i] = ins_here[i] ? new_e : below[i];
          end
        end
        count_next = count + 1'b1;
      end else if (lt[0]) begin
        for (int i = 0; i < TABLE_CAPACITY; i++) begin
          if (lt_above[i]) begin
            table_next[i] = above[i];
          end else if (lt[i]) begin
            table_next[i] = new_e;
          end
        end
      end
    end else if (dp_cmd.ack && any_hit) begin
      for (int i = 0; i < TABLE_CAPACITY; i++) begin
        if (!lt[i]) begin
          table_next[i] = above[i];
        end
      end
      count_next = count - 1'b1;
    end else if (dp_cmd.step) begin
      if (dp_status.remove) begin
        for (int i = 0; i < TABLE_CAPACITY; i++) begin
          if (CNT_W'(i) >= dp_cmd.idx) begin
            table_next[i] = above[i];
          end
        end
        count_next = count - 1'b1;
      end else begin
        table_next[dp_cmd.idx[IDX_W-1:0]].sent_time = r_now;
        table_next[dp_cmd.idx[IDX_W-1:0]].unsent = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
      count <= '0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_data;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    table_r <= table_next;
    if (dp_cmd.load) begin
      r_type <= msg_type;
      r_payload <= msg_payload;
      r_ack <= needs_ack;
      r_now <= now_time;
      r_ready <= link_ready;
    end
    if (dp_cmd.push) begin
      send_type <= cand_type;
      send_payload <= cand_payload;
      send_accepted <= r_ready;
      last_send <= dp_cmd.last;
    end
    if (dp_cmd.step) begin
      cand_type <= cur.msg_type;
      cand_payload <= cur.msg_payload;
    end
  end

endmodule

// ===== hw/rtl/rpt_ctrl.sv =====
module rpt_ctrl import rpt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  logic [OP_W-1:0] operation,
  output logic            send_valid,
  input  logic            send_ready,
  output dp_cmd_t         dp_cmd,
  input  dp_status_t      dp_status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_ACK = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic             cand_valid;
  logic             cand_valid_next;
  logic             out_valid;
  logic             out_valid_next;
  logic             out_free;

  always_comb begin
    state_next = state;
    idx_next = idx;
    cand_valid_next = cand_valid;
    dp_cmd = '0;
    cmd_ready = (state == ST_IDLE);
    out_free = !out_valid || send_ready;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          dp_cmd.load = 1'b1;
          unique case (operation)
            OP_WRITE: state_next = ST_WRITE;
            OP_ACK:   state_next = ST_ACK;
            OP_TICK: begin
              idx_next = '0;
              state_next = ST_SCAN;
            end
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        dp_cmd.write = 1'b1;
        state_next = ST_IDLE;
      end
      ST_ACK: begin
        dp_cmd.ack = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (idx == dp_status.count) begin
          state_next = ST_FLUSH;
        end else if (!dp_status.due) begin
          idx_next = idx + 1'b1;
        end else if (!cand_valid || out_free) begin
          dp_cmd.step = 1'b1;
          dp_cmd.push = cand_valid;
          cand_valid_next = 1'b1;
          if (!dp_status.remove) begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!cand_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          dp_cmd.push = 1'b1;
          dp_cmd.last = 1'b1;
          cand_valid_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    dp_cmd.idx = idx;
    out_valid_next = dp_cmd.push || (out_valid && !send_ready);
    send_valid = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      cand_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      cand_valid <= cand_valid_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench import rpt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_CYCLES = 30;

  typedef struct packed {
    logic [TYPE_W-1:0]    send_type;
    logic [PAYLOAD_W-1:0] send_payload;
    logic                 send_accepted;
    logic                 last_send;
  } send_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpt_cmd_if  cmd_bus ();
  rpt_send_if send_bus ();
  rpt_cfg_if  cfg_bus ();

  retransmit_pending_table dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_bus),
    .send (send_bus),
    .cfg  (cfg_bus)
  );

  // Copy of the table, indexed directly by message type.
  logic                 tbl_valid     [0:255];
  logic [PAYLOAD_W-1:0] tbl_payload   [0:255];
  logic                 tbl_needs_ack [0:255];
  logic [TIME_W-1:0]    tbl_sent_time [0:255];
  logic                 tbl_unsent    [0:255];
  int                   tbl_count;
  logic [TIMEOUT_W-1:0] retry_timeout_q;

  send_beat_t        pending_sends[$];
  int                errors = 0;
  bit                src_idle = 1'b0;
  bit                sink_idle = 1'b0;
  int                sink_stall = 0;
  logic [TIME_W-1:0] clock_now = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void expect_add(input send_beat_t beat);
    pending_sends.insert(pending_sends.size(), beat);
  endfunction

  function automatic send_beat_t expect_take();
    send_beat_t beat;
    beat = pending_sends[0];
    pending_sends.delete(0);
    return beat;
  endfunction

  function automatic void store_write(input logic [TYPE_W-1:0] kind,
                                      input logic [PAYLOAD_W-1:0] payload,
                                      input logic ack);
    int lowest;
    if (!tbl_valid[kind]) begin
      if (tbl_count == TABLE_CAPACITY) begin
        lowest = -1;
        for (int i = 0; i < 256; i++) begin
          if (tbl_valid[i] && lowest < 0) lowest = i;
        end
        if (lowest > int'(kind)) return;
        tbl_valid[lowest] = 1'b0;
        tbl_count--;
      end
      tbl_count++;
    end
    tbl_valid[kind] = 1'b1;
    tbl_payload[kind] = payload;
    tbl_needs_ack[kind] = ack;
    tbl_sent_time[kind] = '0;
    tbl_unsent[kind] = 1'b1;
  endfunction

  function automatic void drop_acked(input logic [TYPE_W-1:0] kind);
    if (tbl_valid[kind]) begin
      tbl_valid[kind] = 1'b0;
      tbl_count--;
    end
  endfunction

  function automatic void scan_due(input logic [TIME_W-1:0] now, input logic link);
    logic [TIME_W-1:0] age;
    int emitted;
    send_beat_t beat;
    emitted = 0;
    for (int t = 0; t < 256; t++) begin
      if (!tbl_valid[t]) continue;
      age = now - tbl_sent_time[t];
      if (!tbl_unsent[t] && age < {16'd0, retry_timeout_q}) continue;
      beat.send_type = TYPE_W'(t);
      beat.send_payload = tbl_payload[t];
      beat.send_accepted = link;
      beat.last_send = 1'b0;
      expect_add(beat);
      emitted++;
      if (link && !tbl_needs_ack[t]) begin
        tbl_valid[t] = 1'b0;
        tbl_count--;
      end else begin
        tbl_sent_time[t] = now;
        tbl_unsent[t] = 1'b0;
      end
    end
    if (emitted > 0) pending_sends[pending_sends.size() - 1].last_send = 1'b1;
  endfunction

  always @(posedge clk) begin : check_send
    send_beat_t want;
    if (!rst && send_bus.valid && send_bus.ready) begin
      if (pending_sends.size() == 0) begin
        $error("send beat with no expectation: send_type %0d", send_bus.send_type);
        errors++;
      end else begin
        want = expect_take();
        if (send_bus.send_type !== want.send_type) begin
          $error("send_type: expected %0d, actual %0d", want.send_type, send_bus.send_type);
          errors++;
        end
        if (send_bus.send_payload !== want.send_payload) begin
          $error("send_payload: expected %h, actual %h", want.send_payload,
                 send_bus.send_payload);
          errors++;
        end
        if (send_bus.send_accepted !== want.send_accepted) begin
          $error("send_accepted: expected %0b, actual %0b", want.send_accepted,
                 send_bus.send_accepted);
          errors++;
        end
        if (send_bus.last_send !== want.last_send) begin
          $error("last_send: expected %0b, actual %0b", want.last_send, send_bus.last_send);
          errors++;
        end
      end
      sink_stall = sink_idle ? $urandom_range(0, 18) : 0;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        send_bus.ready <= 1'b0;
        sink_stall--;
      end else begin
        send_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TYPE_W-1:0] kind,
                           input logic [PAYLOAD_W-1:0] payload, input logic ack,
                           input logic [TIME_W-1:0] now, input logic link);
    int gap;
    gap = src_idle ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.msg_type <= kind;
    cmd_bus.msg_payload <= payload;
    cmd_bus.needs_ack <= ack;
    cmd_bus.now_time <= now;
    cmd_bus.link_ready <= link;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    case (op)
      OP_WRITE: store_write(kind, payload, ack);
      OP_ACK:   drop_acked(kind);
      OP_TICK:  scan_due(now, link);
      default:  ;
    endcase
  endtask

  task automatic write_msg(input logic [TYPE_W-1:0] kind, input logic [PAYLOAD_W-1:0] payload,
                           input logic ack);
    send_item(OP_WRITE, kind, payload, ack, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic ack_msg(input logic [TYPE_W-1:0] kind);
    send_item(OP_ACK, kind, {$urandom, $urandom}, 1'($urandom_range(0, 1)), $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic tick(input logic [TIME_W-1:0] now, input logic link);
    send_item(OP_TICK, TYPE_W'($urandom_range(0, 255)), {$urandom, $urandom},
              1'($urandom_range(0, 1)), now, link);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (pending_sends.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.retry_timeout <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    retry_timeout_q = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(0, 3) == 0) return TYPE_W'($urandom_range(0, 255));
    return TYPE_W'($urandom_range(40, 63));
  endfunction

  task automatic test_resend_and_ack();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    write_msg(8'd0, '1, 1'b1);
    tick(32'd0, 1'b1);
    tick(32'd499, 1'b1);
    tick(32'd500, 1'b1);
    ack_msg(8'd0);
    ack_msg(8'd0);
    send_item(OP_UNUSED, 8'd0, '1, 1'b1, 32'd600, 1'b1);
    clock_now = 32'd500;
  endtask

  task automatic test_full_table();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    for (int k = 0; k < 16; k++) begin
      write_msg(TYPE_W'(100 + 10 * k),
                (k % 3 == 0) ? '1 : (k % 3 == 1) ? '0 : {$urandom, $urandom}, k[0]);
    end
    write_msg(8'd110, {$urandom, $urandom}, 1'b1);
    write_msg(8'd255, {$urandom, $urandom}, 1'b0);
    write_msg(8'd50, {$urandom, $urandom}, 1'b1);
    tick(32'd1000, 1'b0);
    tick(32'd2000, 1'b1);
    clock_now = 32'd2000;
  endtask

  task automatic test_timeout_limits();
    sink_idle = 1'b0;
    write_timeout('0);
    tick(32'd2000, 1'b1);
    tick(32'd2000, 1'b0);
    write_timeout('1);
    tick(32'd2000 + 32'd65534, 1'b1);
    tick(32'd2000 + 32'd65535, 1'b1);
    clock_now = 32'd2000 + 32'd65535;
  endtask

  task automatic run_random_phase(input int items, input logic [TIMEOUT_W-1:0] timeout,
                                  input int idle_mode);
    int done;
    int pick;
    write_timeout(timeout);
    src_idle = (idle_mode == 2) ? 1'($urandom_range(0, 1)) : (idle_mode == 1);
    sink_idle = (idle_mode == 2) ? 1'($urandom_range(0, 1)) : (idle_mode == 1);
    if ($urandom_range(0, 2) == 0) clock_now = 32'hFFFF_0000 + $urandom_range(0, 65535);
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(OP_UNUSED, pick_type(), {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                  $urandom, 1'($urandom_range(0, 1)));
      end else begin
        done++;
        if (pick < 45) begin
          write_msg(pick_type(), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else if (pick < 62) begin
          ack_msg(pick_type());
        end else begin
          if ($urandom_range(0, 19) == 0) clock_now = $urandom;
          else clock_now += $urandom_range(0, 2 * int'(timeout));
          tick(clock_now, $urandom_range(0, 3) != 0);
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(24, 16'd1, 0);
    run_random_phase(24, TIMEOUT_W'($urandom_range(2, 40)), 1);
    run_random_phase(24, TIMEOUT_W'($urandom_range(1, 65535)), 2);
    run_random_phase(24, 16'd65535, 2);
    run_random_phase(24, TIMEOUT_W'($urandom_range(2, 300)), 2);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    retry_timeout_q = TIMEOUT_RESET;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = OP_WRITE;
    cmd_bus.msg_type = '0;
    cmd_bus.msg_payload = '0;
    cmd_bus.needs_ack = 1'b0;
    cmd_bus.now_time = '0;
    cmd_bus.link_ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.retry_timeout = TIMEOUT_RESET;
    send_bus.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_resend_and_ack();
    test_full_table();
    test_timeout_limits();
    test_random_traffic();

    wait_quiet();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== retransmit_pending_table.f =====
+incdir+hw/rtl
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_if.sv
hw/rtl/rpt_datapath.sv
hw/rtl/rpt_ctrl.sv
hw/rtl/retransmit_pending_table.sv
verif/testbench.sv
